// File: rtl/additive_sine_partials_macros.svh
// Assertion macros shared by the additive sine partials RTL
`ifndef ADDITIVE_SINE_PARTIALS_MACROS_SVH
`define ADDITIVE_SINE_PARTIALS_MACROS_SVH

// Check that a condition implies another in the same cycle, outside reset
`define ASP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another in the next cycle, outside reset
`define ASP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/asp_pkg.sv
// Package with types, constants and the sine table builder of the additive synthesiser
`timescale 1ns / 1ps

package asp_pkg;

    // Defaults of the top-level parameters
    localparam int MAX_PARTIALS_DEF    = 16;
    localparam int SINE_TABLE_BITS_DEF = 10;

    // Field widths
    localparam int IDX_W   = 4;
    localparam int FREQ_W  = 24;
    localparam int AMP_W   = 16;
    localparam int TIME_W  = 32;
    localparam int CNT_W   = 5;
    localparam int OUT_W   = 32;
    localparam int IN_W    = 80;
    localparam int PHASE_W = 32;
    localparam int MAG_W   = 15;
    localparam int SINE_W  = 16;
    localparam int PROD_W  = 32;

    // Input tdata layout, lowest field first
    localparam int IDX_LSB  = 0;
    localparam int FREQ_LSB = IDX_LSB + IDX_W;
    localparam int AMP_LSB  = FREQ_LSB + FREQ_W;
    localparam int TIME_LSB = AMP_LSB + AMP_W;

    // Request kinds carried in tuser
    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    // Reset contents of entry 0: 440 Hz and unity gain
    localparam logic [FREQ_W-1:0] FREQ_RESET = 24'd112640;
    localparam logic [AMP_W-1:0]  AMP_RESET  = 16'd4096;

    // Output rounding and range
    localparam int RND_SHIFT = 11;
    localparam int RND_BIAS  = 1024;
    localparam int OUT_MAX   = 8388607;
    localparam int OUT_MIN   = -8388608;

    // pi/2 in Q30
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // One partial as held in the table
    typedef struct packed {
        logic [FREQ_W-1:0] freq;
        logic [AMP_W-1:0]  amp;
    } t_entry;

    // Tag that travels with each partial through the pipeline
    typedef struct packed {
        logic vld;
        logic last;
    } t_tag;

    // One quarter-wave entry: Taylor series in Q30, rounded to Q1.15
    function automatic logic [MAG_W-1:0] quarter_entry(input int unsigned idx,
                                                       input int unsigned bits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] prod;
        logic [63:0] r;
        int          k;
        x    = (64'(idx) * HALF_PI_Q30) >> bits;
        x2   = (x * x) >> 30;
        term = x;
        pos  = x;
        neg  = 64'd0;
        for (k = 1; k <= 7; k++) begin
            prod = (term * x2) >> 30;
            case (k)
                1:       term = prod / 64'd6;
                2:       term = prod / 64'd20;
                3:       term = prod / 64'd42;
                4:       term = prod / 64'd72;
                5:       term = prod / 64'd110;
                6:       term = prod / 64'd156;
                default: term = prod / 64'd210;
            endcase
            if (k[0]) begin
                neg = neg + term;
            end else begin
                pos = pos + term;
            end
        end
        r = (pos >= neg) ? (pos - neg) : 64'd0;
        r = (r + 64'd16384) >> 15;
        if (r > 64'd32767) begin
            r = 64'd32767;
        end
        return r[MAG_W-1:0];
    endfunction

endpackage

// File: rtl/additive_sine_partials.sv
// Top level of the additive sine synthesiser: control, phase multiplier and ports
//
//  Channel   Dir  Handshake               Payload
//  s_axis    in   s_axis_tvalid/tready    tdata: index, freq, amp, time; tuser: kind
//  m_axis    out  m_axis_tvalid/tready    tdata: sample; tuser: saturated flag
//  cfg       in   i_cfg_valid/o_cfg_ready i_cfg_data: partial count
//
//  A write item leaves the block idle. A sample item occupies the block
//  while it runs: the partial memory gives one entry per cycle,
//  followed by the phase, sine, multiply, accumulate and rounding stages.
//  The finished sample sits in an output register, so the next item is
//  taken while it waits; a second finished sample holds until it drains.
//  Reset is synchronous and active low and restores the partial table.
`timescale 1ns / 1ps
`include "additive_sine_partials_macros.svh"

module additive_sine_partials #(
    parameter int MAX_PARTIALS    = asp_pkg::MAX_PARTIALS_DEF,
    parameter int SINE_TABLE_BITS = asp_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // tdata: partial_index[3:0], partial_freq[27:4], partial_amp[43:28],
    //        sample_time[75:44], zero padding[79:76]
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [asp_pkg::IN_W-1:0]     s_axis_tdata,
    // tuser: req_type[0]
    input  logic [0:0]                   s_axis_tuser,
    // tdata: sample_value[31:0]
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [asp_pkg::OUT_W-1:0]    m_axis_tdata,
    // tuser: saturated[0]
    output logic [0:0]                   m_axis_tuser,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [asp_pkg::CNT_W-1:0]    i_cfg_data
);

    localparam int AW = (MAX_PARTIALS > 1) ? $clog2(MAX_PARTIALS) : 1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RUN  = 4'b0010,
        S_WAIT = 4'b0100,
        S_HOLD = 4'b1000
    } t_state;

    t_state                          r_state;
    t_state                          n_state;
    logic [asp_pkg::CNT_W-1:0]       r_count;
    logic [asp_pkg::TIME_W-1:0]      r_time;
    logic [AW-1:0]                   r_idx;
    logic [AW-1:0]                   r_last;
    logic [7:0]                      w_count8;
    logic [7:0]                      w_n;
    logic                            w_in_acc;
    logic                            w_sample;
    logic                            w_issue;
    asp_pkg::t_tag                   w_tag0;
    asp_pkg::t_tag                   r_tag1;
    asp_pkg::t_tag                   r_tag2;
    asp_pkg::t_tag                   r_tag3;
    asp_pkg::t_entry                 w_wr_entry;
    asp_pkg::t_entry                 w_rd_entry;
    logic [asp_pkg::PHASE_W-1:0]     w_freq32;
    logic [asp_pkg::PHASE_W-1:0]     w_phase;
    logic [asp_pkg::PHASE_W-1:0]     r_phase;
    logic [asp_pkg::AMP_W-1:0]       r_amp2;
    logic [asp_pkg::AMP_W-1:0]       r_amp3;
    logic [asp_pkg::MAG_W-1:0]       w_mag;
    logic                            w_neg;
    logic                            w_done;
    logic [asp_pkg::OUT_W-1:0]       w_value;
    logic                            w_sat;
    logic                            w_load;
    logic                            r_out_vld;
    logic [asp_pkg::OUT_W-1:0]       r_out_value;
    logic                            r_out_sat;

    // Input handshake
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid & s_axis_tready;
    assign w_sample      = w_in_acc & (s_axis_tuser[0] == asp_pkg::REQ_SAMPLE);

    // Configuration register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= asp_pkg::CNT_W'(1);
        end else if (i_cfg_valid) begin
            r_count <= i_cfg_data;
        end
    end

    // Clamp the partial count to one through the table depth
    assign w_count8 = {3'b000, r_count};
    assign w_n = (w_count8 == 8'd0) ? 8'd1
               : ((w_count8 > 8'(MAX_PARTIALS)) ? 8'(MAX_PARTIALS) : w_count8);

    // Sequence one sample
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_sample) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (r_idx == r_last) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (w_done) begin
                    n_state = (!r_out_vld || m_axis_tready) ? S_IDLE : S_HOLD;
                end
            end
            S_HOLD: begin
                if (m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Hold the sample time and walk the partial index
    always_ff @(posedge i_clk) begin
        if (w_sample) begin
            r_time <= s_axis_tdata[asp_pkg::TIME_LSB +: asp_pkg::TIME_W];
            r_idx  <= '0;
            r_last <= AW'(w_n - 8'd1);
        end else if (w_issue) begin
            r_idx <= r_idx + AW'(1);
        end
    end

    assign w_issue     = (r_state == S_RUN);
    assign w_tag0.vld  = w_issue;
    assign w_tag0.last = (r_idx == r_last);

    // Partial table
    assign w_wr_entry.freq = s_axis_tdata[asp_pkg::FREQ_LSB +: asp_pkg::FREQ_W];
    assign w_wr_entry.amp  = s_axis_tdata[asp_pkg::AMP_LSB +: asp_pkg::AMP_W];

    asp_ptab #(
        .MAX_PARTIALS (MAX_PARTIALS),
        .AW           (AW)
    ) u_ptab (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (w_in_acc & (s_axis_tuser[0] == asp_pkg::REQ_WRITE)),
        .i_wr_idx   (s_axis_tdata[asp_pkg::IDX_LSB +: asp_pkg::IDX_W]),
        .i_wr_entry (w_wr_entry),
        .i_rd_en    (w_issue),
        .i_rd_addr  (r_idx),
        .o_rd_entry (w_rd_entry)
    );

    // Phase is the low word of time times frequency
    assign w_freq32 = {{(asp_pkg::PHASE_W - asp_pkg::FREQ_W){w_rd_entry.freq[asp_pkg::FREQ_W-1]}},
                       w_rd_entry.freq};
    assign w_phase  = r_time * w_freq32;

    always_ff @(posedge i_clk) begin
        r_phase <= w_phase;
        r_amp2  <= w_rd_entry.amp;
        r_amp3  <= r_amp2;
    end

    // Advance the pipeline tags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1 <= '0;
            r_tag2 <= '0;
            r_tag3 <= '0;
        end else begin
            r_tag1 <= w_tag0;
            r_tag2 <= r_tag1;
            r_tag3 <= r_tag2;
        end
    end

    asp_sine_rom #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_sine_rom (
        .i_clk   (i_clk),
        .i_phase (r_phase),
        .o_mag   (w_mag),
        .o_neg   (w_neg)
    );

    asp_mac #(
        .MAX_PARTIALS (MAX_PARTIALS)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (w_sample),
        .i_tag   (r_tag3),
        .i_mag   (w_mag),
        .i_neg   (w_neg),
        .i_amp   ($signed(r_amp3)),
        .o_done  (w_done),
        .o_value (w_value),
        .o_sat   (w_sat)
    );

    // Output register
    assign w_load = ((r_state == S_WAIT) && w_done && (!r_out_vld || m_axis_tready))
                 || ((r_state == S_HOLD) && m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_load) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_value <= w_value;
            r_out_sat   <= w_sat;
        end
    end

    assign m_axis_tvalid   = r_out_vld;
    assign m_axis_tdata    = r_out_value;
    assign m_axis_tuser[0] = r_out_sat;

    `ASP_ASSERT_SAME(a_idle_pipe_empty, i_clk, i_rst_n, s_axis_tready,
        !r_tag1.vld && !r_tag2.vld && !r_tag3.vld, "pipeline busy while idle")
    `ASP_ASSERT_SAME(a_done_in_wait, i_clk, i_rst_n, w_done,
        r_state == S_WAIT, "sum finished outside the wait state")
    `ASP_ASSERT_NEXT(a_sample_starts, i_clk, i_rst_n, w_sample,
        r_state == S_RUN && r_idx == '0, "sample item did not start a run")
    `ASP_ASSERT_NEXT(a_write_stays_idle, i_clk, i_rst_n,
        w_in_acc && (s_axis_tuser[0] == asp_pkg::REQ_WRITE),
        r_state == S_IDLE, "write item left the idle state")

endmodule

// File: rtl/asp_ptab.sv
// Partial table: one synchronous memory of frequency and amplitude pairs
`timescale 1ns / 1ps

module asp_ptab #(
    parameter int MAX_PARTIALS = asp_pkg::MAX_PARTIALS_DEF,
    parameter int AW           = 4
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_wr_en,
    input  logic [asp_pkg::IDX_W-1:0] i_wr_idx,
    input  asp_pkg::t_entry           i_wr_entry,
    input  logic                      i_rd_en,
    input  logic [AW-1:0]             i_rd_addr,
    output asp_pkg::t_entry           o_rd_entry
);

    asp_pkg::t_entry   r_mem [MAX_PARTIALS];
    logic [MAX_PARTIALS-1:0] r_valid;
    asp_pkg::t_entry   r_rd_data;
    logic              r_rd_hit;
    logic              r_rd_zero;
    logic              w_in_range;
    logic [AW-1:0]     w_wr_addr;
    asp_pkg::t_entry   w_reset_entry;

    // Drop writes beyond the table
    assign w_in_range = ({3'b000, i_wr_idx} < 7'(MAX_PARTIALS));
    assign w_wr_addr  = AW'(i_wr_idx);

    // Store the written entry
    always_ff @(posedge i_clk) begin
        if (i_wr_en && w_in_range) begin
            r_mem[w_wr_addr] <= i_wr_entry;
        end
    end

    // Mark entries once written; unwritten entries read as their reset value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en && w_in_range) begin
            r_valid[w_wr_addr] <= 1'b1;
        end
    end

    // Registered read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
            r_rd_hit  <= r_valid[i_rd_addr];
            r_rd_zero <= (i_rd_addr == '0);
        end
    end

    assign w_reset_entry.freq = r_rd_zero ? asp_pkg::FREQ_RESET : '0;
    assign w_reset_entry.amp  = r_rd_zero ? asp_pkg::AMP_RESET : '0;
    assign o_rd_entry         = r_rd_hit ? r_rd_data : w_reset_entry;

endmodule

// File: rtl/asp_sine_rom.sv
// Quarter-wave sine ROM with quadrant folding and a registered read
`timescale 1ns / 1ps

module asp_sine_rom #(
    parameter int SINE_TABLE_BITS = asp_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic [asp_pkg::PHASE_W-1:0]   i_phase,
    output logic [asp_pkg::MAG_W-1:0]     o_mag,
    output logic                          o_neg
);

    localparam int QLEN = 1 << SINE_TABLE_BITS;
    localparam int RW   = SINE_TABLE_BITS + 1;

    typedef logic [asp_pkg::MAG_W-1:0] t_rom [QLEN + 1];

    function automatic t_rom build_rom();
        t_rom rom;
        int   i;
        for (i = 0; i <= QLEN; i++) begin
            rom[i] = asp_pkg::quarter_entry(i, SINE_TABLE_BITS);
        end
        return rom;
    endfunction

    localparam t_rom ROM_DATA = build_rom();

    logic [SINE_TABLE_BITS-1:0] w_idx;
    logic [RW-1:0]              w_addr;
    logic [asp_pkg::MAG_W-1:0]  r_mag;
    logic                       r_neg;

    // Fold the phase onto the first quadrant
    assign w_idx  = i_phase[asp_pkg::PHASE_W-3 -: SINE_TABLE_BITS];
    assign w_addr = i_phase[asp_pkg::PHASE_W-2] ? (RW'(QLEN) - {1'b0, w_idx})
                                                : {1'b0, w_idx};

    // Read the table; the upper half of the wave is negated downstream
    always_ff @(posedge i_clk) begin
        r_mag <= ROM_DATA[w_addr];
        r_neg <= i_phase[asp_pkg::PHASE_W-1];
    end

    assign o_mag = r_mag;
    assign o_neg = r_neg;

endmodule

// File: rtl/asp_mac.sv
// Weighting multiplier, accumulator and output rounding with saturation
`timescale 1ns / 1ps

module asp_mac #(
    parameter int MAX_PARTIALS = asp_pkg::MAX_PARTIALS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_clear,
    input  asp_pkg::t_tag                      i_tag,
    input  logic [asp_pkg::MAG_W-1:0]          i_mag,
    input  logic                               i_neg,
    input  logic signed [asp_pkg::AMP_W-1:0]   i_amp,
    output logic                               o_done,
    output logic [asp_pkg::OUT_W-1:0]          o_value,
    output logic                               o_sat
);

    localparam int ACC_W = asp_pkg::PROD_W + $clog2(MAX_PARTIALS) + 1;
    localparam logic signed [ACC_W-1:0] BIAS   = ACC_W'(asp_pkg::RND_BIAS);
    localparam logic signed [ACC_W-1:0] OUT_HI = ACC_W'(asp_pkg::OUT_MAX);
    localparam logic signed [ACC_W-1:0] OUT_LO = ACC_W'(asp_pkg::OUT_MIN);

    logic signed [asp_pkg::SINE_W-1:0] w_sine;
    logic signed [asp_pkg::PROD_W-1:0] r_prod;
    asp_pkg::t_tag                     r_tag;
    logic signed [ACC_W-1:0]           r_acc;
    logic                              r_done;
    logic signed [ACC_W-1:0]           w_sum;
    logic signed [ACC_W-1:0]           w_rnd;
    logic signed [ACC_W-1:0]           w_clip;

    // Apply the quadrant sign
    assign w_sine = i_neg ? -$signed({1'b0, i_mag}) : $signed({1'b0, i_mag});

    // Weight the sine by the amplitude
    always_ff @(posedge i_clk) begin
        r_prod <= w_sine * i_amp;
    end

    // Advance the tag alongside the product
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag  <= '0;
            r_done <= 1'b0;
        end else begin
            r_tag  <= i_tag;
            r_done <= r_tag.vld & r_tag.last;
        end
    end

    // Accumulate the terms of one sample
    always_ff @(posedge i_clk) begin
        if (i_clear) begin
            r_acc <= '0;
        end else if (r_tag.vld) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    // Round half up to Q8.16 and clip to range
    assign w_sum  = r_acc + BIAS;
    assign w_rnd  = w_sum >>> asp_pkg::RND_SHIFT;
    assign o_sat  = (w_rnd > OUT_HI) || (w_rnd < OUT_LO);
    assign w_clip = (w_rnd > OUT_HI) ? OUT_HI : ((w_rnd < OUT_LO) ? OUT_LO : w_rnd);

    assign o_value = w_clip[asp_pkg::OUT_W-1:0];
    assign o_done  = r_done;

endmodule
